// File: src/hpw_pkg.sv
// ----------------------------------------------------------------------------
// hpw_pkg: shared types and constants of the homography pixel-to-world block
// formats, register indexes, divider sizing and pipeline control words
// ----------------------------------------------------------------------------
package hpw_pkg;

	localparam int PIXEL_FRAC_BITS_DEF = 4;
	localparam int PIXEL_W             = 16;
	localparam int COEF_W              = 32;
	localparam int GAINS_W             = 64;
	localparam int WORLD_W             = 32;
	localparam int INDEX_W             = 8;
	localparam int PROD_W              = COEF_W + PIXEL_W + 1;
	// numerator magnitudes fit below 2^50 for every fraction setting
	localparam int NUM_W               = 51;
	// denominator width grows with the h8 scale of 2^(14+frac)
	localparam int DEN_W_BASE          = 51;
	localparam int DEN_SHIFT_BASE      = 14;
	// quotient bits kept: 32 result bits plus one for the range check
	localparam int QUOT_BITS           = 33;
	localparam int QUOT_EXTRA          = 26;
	localparam int FRONT_STAGES        = 3;
	localparam int LATENCY             = FRONT_STAGES + 1 + QUOT_BITS + 1;

	localparam logic [QUOT_BITS-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUOT_BITS-1:0] LIMIT_NEG = 33'h0_8000_0000;

	typedef enum logic [INDEX_W-1:0] {
		REG_X_GAIN_X   = 8'd0,
		REG_X_GAIN_Y   = 8'd1,
		REG_X_OFFSET   = 8'd2,
		REG_Y_GAIN_X   = 8'd3,
		REG_Y_GAIN_Y   = 8'd4,
		REG_Y_OFFSET   = 8'd5,
		REG_DEN_GAINS  = 8'd6,
		REG_DEN_OFFSET = 8'd7
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic bad;
		logic neg_x;
		logic neg_y;
	} front_ctl_t;

	typedef struct packed {
		logic valid;
		logic bad;
		logic neg;
	} div_ctl_t;

endpackage

// File: src/hpw_front.sv
// ----------------------------------------------------------------------------
// hpw_front: products, sums and magnitudes
// three stages: multiply, accumulate, sign split with zero-denominator flag
// ----------------------------------------------------------------------------
module hpw_front #(
	parameter int PIXEL_FRAC_BITS = hpw_pkg::PIXEL_FRAC_BITS_DEF,
	parameter int DEN_W           = hpw_pkg::DEN_W_BASE + PIXEL_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [hpw_pkg::PIXEL_W-1:0]           pixel_x,
	input  logic [hpw_pkg::PIXEL_W-1:0]           pixel_y,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h0,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h1,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h2,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h3,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h4,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h5,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h6,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h7,
	input  logic signed [hpw_pkg::COEF_W-1:0]     h8,
	output hpw_pkg::front_ctl_t                   ctl,
	output logic [hpw_pkg::NUM_W-1:0]             num_x_mag,
	output logic [hpw_pkg::NUM_W-1:0]             num_y_mag,
	output logic [DEN_W-1:0]                      den_mag
);
	import hpw_pkg::*;

	localparam int DEN_SHIFT = DEN_SHIFT_BASE + PIXEL_FRAC_BITS;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p3_s1, p4_s1, p6_s1, p7_s1;
	logic signed [NUM_W-1:0]  nx_s2, ny_s2;
	logic signed [DEN_W-1:0]  den_s2;
	logic [NUM_W-1:0]         nx_s3, ny_s3;
	logic [DEN_W-1:0]         den_s3;
	logic                     bad_s3, negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: one multiplier per product
	always_ff @(posedge clk) begin
		p0_s1 <= h0 * $signed({1'b0, pixel_x});
		p1_s1 <= h1 * $signed({1'b0, pixel_y});
		p3_s1 <= h3 * $signed({1'b0, pixel_x});
		p4_s1 <= h4 * $signed({1'b0, pixel_y});
		p6_s1 <= h6 * $signed({1'b0, pixel_x});
		p7_s1 <= h7 * $signed({1'b0, pixel_y});
	end

	// stage 2: three-term sums, offsets aligned by shift
	always_ff @(posedge clk) begin
		nx_s2  <= NUM_W'(p0_s1) + NUM_W'(p1_s1) + (NUM_W'(h2) <<< PIXEL_FRAC_BITS);
		ny_s2  <= NUM_W'(p3_s1) + NUM_W'(p4_s1) + (NUM_W'(h5) <<< PIXEL_FRAC_BITS);
		den_s2 <= DEN_W'(p6_s1) + DEN_W'(p7_s1) + (DEN_W'(h8) <<< DEN_SHIFT);
	end

	// stage 3: sign and magnitude
	always_ff @(posedge clk) begin
		nx_s3   <= nx_s2[NUM_W-1] ? NUM_W'(-nx_s2) : NUM_W'(nx_s2);
		ny_s3   <= ny_s2[NUM_W-1] ? NUM_W'(-ny_s2) : NUM_W'(ny_s2);
		den_s3  <= den_s2[DEN_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);
		bad_s3  <= (den_s2 == '0);
		negx_s3 <= nx_s2[NUM_W-1] ^ den_s2[DEN_W-1];
		negy_s3 <= ny_s2[NUM_W-1] ^ den_s2[DEN_W-1];
	end

	assign ctl.valid = vld_s3;
	assign ctl.bad   = bad_s3;
	assign ctl.neg_x = negx_s3;
	assign ctl.neg_y = negy_s3;
	assign num_x_mag = nx_s3;
	assign num_y_mag = ny_s3;
	assign den_mag   = den_s3;

endmodule

// File: src/hpw_div.sv
// ----------------------------------------------------------------------------
// hpw_div: pipelined restoring divider, one quotient bit per stage
// computes n * 2^26 / d truncated, with range check and sign applied
// ----------------------------------------------------------------------------
module hpw_div #(
	parameter int DEN_W = hpw_pkg::DEN_W_BASE + hpw_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hpw_pkg::div_ctl_t                 ctl_in,
	input  logic [hpw_pkg::NUM_W-1:0]         num_mag,
	input  logic [DEN_W-1:0]                  den_mag,
	output logic                              out_valid,
	output logic                              out_ok,
	output logic [hpw_pkg::WORLD_W-1:0]       quot
);
	import hpw_pkg::*;

	localparam int RW  = DEN_W + 1;
	localparam int LOW = QUOT_BITS - QUOT_EXTRA;
	localparam int QB  = QUOT_BITS;

	logic [RW-1:0]    rem_s [0:QB];
	logic [DEN_W-1:0] den_s [0:QB];
	logic [QB-1:0]    q_s   [0:QB];
	logic [QB-1:0]    sr_s  [0:QB];
	logic             vld_s [0:QB];
	logic             bad_s [0:QB];
	logic             neg_s [0:QB];
	logic             ovf_s [0:QB];
	logic [RW-1:0]    hi;
	logic             vld_q, ok_q;
	logic [WORLD_W-1:0] quot_q;

	assign hi = RW'(num_mag >> LOW);

	// entry stage: top bits form the first remainder, early overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= hi;
		den_s[0] <= den_mag;
		q_s[0]   <= '0;
		sr_s[0]  <= {num_mag[LOW-1:0], {QUOT_EXTRA{1'b0}}};
		bad_s[0] <= ctl_in.bad;
		neg_s[0] <= ctl_in.neg;
		ovf_s[0] <= (hi >= {1'b0, den_mag});
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          fits;

		assign trial = {rem_s[k][RW-2:0], sr_s[k][QB-1]};
		assign fits  = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? (trial - {1'b0, den_s[k]}) : trial;
			q_s[k+1]   <= {q_s[k][QB-2:0], fits};
			sr_s[k+1]  <= {sr_s[k][QB-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			bad_s[k+1] <= bad_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	// range check against the signed 32-bit limit, then apply the sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ok_q  <= 1'b0;
		end else begin
			vld_q <= vld_s[QB];
			ok_q  <= vld_s[QB] && !bad_s[QB] && !ovf_s[QB] &&
				(q_s[QB] <= (neg_s[QB] ? LIMIT_NEG : LIMIT_POS));
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= neg_s[QB] ? WORLD_W'(~q_s[QB] + 1'b1) : q_s[QB][WORLD_W-1:0];
	end

	assign out_valid = vld_q;
	assign out_ok    = ok_q;
	assign quot      = quot_q;

endmodule

// File: src/homography_pixel_to_world.sv
// ----------------------------------------------------------------------------
// homography_pixel_to_world: planar homography, pixel to world point
// maps a Q12.4 pixel through a 3x3 matrix to a Q20.12 point in millimeters
// ----------------------------------------------------------------------------
// throughput: one word per cycle; busy is always low
// an accepted start reaches the done strobe through three front stages for
// multiply, sum and sign split and a 33-stage divider pipeline (one
// quotient bit per stage)
// reset clears the pipeline valid bits and loads the identity matrix
// results are shown for one cycle on done; the receiver cannot stall
module homography_pixel_to_world #(
	parameter int PIXEL_FRAC_BITS = hpw_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [hpw_pkg::PIXEL_W-1:0]         pixel_x,
	input  logic [hpw_pkg::PIXEL_W-1:0]         pixel_y,
	output logic                                done,
	output logic signed [hpw_pkg::WORLD_W-1:0]  world_x,
	output logic signed [hpw_pkg::WORLD_W-1:0]  world_y,
	output logic                                point_valid,
	input  logic                                wr_en,
	input  logic [hpw_pkg::INDEX_W-1:0]         wr_index,
	input  logic [hpw_pkg::GAINS_W-1:0]         wr_data
);
	import hpw_pkg::*;

	localparam int DEN_W = DEN_W_BASE + PIXEL_FRAC_BITS;

	// matrix registers
	logic signed [COEF_W-1:0] h0_q, h1_q, h2_q, h3_q, h4_q, h5_q, h8_q;
	logic [GAINS_W-1:0]       dgain_q;

	front_ctl_t       fctl;
	div_ctl_t         dctl_x, dctl_y;
	logic [NUM_W-1:0] nx_mag, ny_mag;
	logic [DEN_W-1:0] den_mag;
	logic             vx, vy, okx, oky;
	logic [WORLD_W-1:0] qx, qy;
	logic             accept;

	// every cycle can take a new word
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q    <= 32'sd65536;
			h1_q    <= '0;
			h2_q    <= '0;
			h3_q    <= '0;
			h4_q    <= 32'sd65536;
			h5_q    <= '0;
			dgain_q <= '0;
			h8_q    <= 32'sd65536;
		end else if (wr_en) begin
			case (wr_index)
				REG_X_GAIN_X:   h0_q    <= wr_data[COEF_W-1:0];
				REG_X_GAIN_Y:   h1_q    <= wr_data[COEF_W-1:0];
				REG_X_OFFSET:   h2_q    <= wr_data[COEF_W-1:0];
				REG_Y_GAIN_X:   h3_q    <= wr_data[COEF_W-1:0];
				REG_Y_GAIN_Y:   h4_q    <= wr_data[COEF_W-1:0];
				REG_Y_OFFSET:   h5_q    <= wr_data[COEF_W-1:0];
				REG_DEN_GAINS:  dgain_q <= wr_data;
				REG_DEN_OFFSET: h8_q    <= wr_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// numerators and shared denominator in fixed point
	hpw_front #(
		.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS),
		.DEN_W(DEN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.h0(h0_q),
		.h1(h1_q),
		.h2(h2_q),
		.h3(h3_q),
		.h4(h4_q),
		.h5(h5_q),
		.h6(dgain_q[COEF_W-1:0]),
		.h7(dgain_q[GAINS_W-1:COEF_W]),
		.h8(h8_q),
		.ctl(fctl),
		.num_x_mag(nx_mag),
		.num_y_mag(ny_mag),
		.den_mag(den_mag)
	);

	assign dctl_x = '{valid: fctl.valid, bad: fctl.bad, neg: fctl.neg_x};
	assign dctl_y = '{valid: fctl.valid, bad: fctl.bad, neg: fctl.neg_y};

	// two dividers in lockstep, one per world axis
	hpw_div #(.DEN_W(DEN_W)) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(dctl_x),
		.num_mag(nx_mag),
		.den_mag(den_mag),
		.out_valid(vx),
		.out_ok(okx),
		.quot(qx)
	);

	hpw_div #(.DEN_W(DEN_W)) u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(dctl_y),
		.num_mag(ny_mag),
		.den_mag(den_mag),
		.out_valid(vy),
		.out_ok(oky),
		.quot(qy)
	);

	// an invalid point reports zeros on both axes
	assign done        = vx && vy;
	assign point_valid = okx && oky;
	assign world_x     = point_valid ? $signed(qx) : '0;
	assign world_y     = point_valid ? $signed(qy) : '0;

endmodule

// File: src/hpw_checker.sv
// ----------------------------------------------------------------------------
// hpw_checker: port-level checks of the homography block
// busy held low, fixed latency, zeroed invalid points, flag tied to the strobe
// ----------------------------------------------------------------------------
module hpw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic signed [hpw_pkg::WORLD_W-1:0]  world_x,
	input logic signed [hpw_pkg::WORLD_W-1:0]  world_y,
	input logic                                point_valid
);
	import hpw_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without a word accepted at the pipeline latency");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !point_valid) |-> (world_x == '0 && world_y == '0))
		else $error("invalid point with nonzero world coordinates");

	a_flag_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !point_valid)
		else $error("point_valid outside a done cycle");

endmodule

bind homography_pixel_to_world hpw_checker u_hpw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.world_x(world_x),
	.world_y(world_y),
	.point_valid(point_valid)
);
